[hw/rtl/bvpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvpc_pkg: shared types and constants of the packet classifier
// Table sizes, item layouts, command and status codes, and the helper that
// turns an action key into its slot.
// ----------------------------------------------------------------------------
package bvpc_pkg;

   localparam int IP_ENTRIES    = 1024;
   localparam int PORT_ENTRIES  = 256;
   localparam int PROTO_ENTRIES = 256;
   localparam int ACT_ENTRIES   = 33;

   localparam int IP_AW    = $clog2(IP_ENTRIES);
   localparam int PORT_AW  = $clog2(PORT_ENTRIES);
   localparam int PROTO_AW = $clog2(PROTO_ENTRIES);
   localparam int ACT_AW   = 6;

   localparam int SCAN_DEPTH = (IP_ENTRIES > PORT_ENTRIES) ? IP_ENTRIES : PORT_ENTRIES;
   localparam int SCAN_AW    = $clog2(SCAN_DEPTH);
   localparam int CLR_DEPTH  = (SCAN_DEPTH > PROTO_ENTRIES) ? SCAN_DEPTH : PROTO_ENTRIES;
   localparam int CLR_AW     = $clog2(CLR_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
   localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [3:0]  IP_VERSION_4  = 4'd4;

   typedef enum logic [1:0] {
      REQ_CLASSIFY = 2'd0,
      REQ_INSERT   = 2'd1,
      REQ_DELETE   = 2'd2,
      REQ_NONE     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      SEL_SRC_ADDR = 3'd0,
      SEL_DST_ADDR = 3'd1,
      SEL_PROTO    = 3'd2,
      SEL_SRC_PORT = 3'd3,
      SEL_DST_PORT = 3'd4,
      SEL_ACTION   = 3'd5
   } sel_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_BAD_KEY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_LOOKUP = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_PASS   = 3'd3,
      CMD_NOP    = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [2:0]  table_select;
      logic [31:0] entry_key;
      logic [31:0] entry_value;
      logic [3:0]  ip_version;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  ttl;
      logic        egress_dir;
   } req_item_type;

   typedef struct packed {
      logic        allowed;
      logic        record_valid;
      logic [1:0]  rec_flags;
      logic [31:0] rule_id;
      logic [7:0]  rec_ttl;
      logic [7:0]  rec_protocol;
      logic [31:0] rec_src_addr;
      logic [31:0] rec_dst_addr;
      logic [15:0] rec_src_port;
      logic [15:0] rec_dst_port;
      logic [1:0]  write_status;
   } rsp_item_type;

   // Decoded item as it waits between the front and the engine. For table
   // writes every key field carries the entry key cut to that table's width.
   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   sel;
      logic [31:0]  key_sa;
      logic [31:0]  key_da;
      logic [7:0]   key_pr;
      logic [15:0]  key_sp;
      logic [15:0]  key_dp;
      logic [31:0]  value;
      logic [7:0]   ttl;
      logic         egress;
      logic         ports;
   } cmd_type;

   // Returns {more than one bit set, slot}; key 0 maps to slot 0, bit b to slot b+1.
   function automatic logic [ACT_AW:0] act_slot(input logic [31:0] key);
      logic [ACT_AW-1:0] slot;
      logic              bad;
      int                b;
      slot = '0;
      bad  = (key & (key - 32'd1)) != 32'd0;
      for (b = 0; b < 32; b++) begin
         if (key[b]) begin
            slot = ACT_AW'(b + 1);
         end
      end
      return {bad, slot};
   endfunction

endpackage
`default_nettype wire

[hw/rtl/bitvector_packet_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitvector_packet_classifier: bit-vector IPv4 packet classifier
// Matches header tuples against five rule tables, ANDs their rule bitmaps,
// picks the lowest matching rule and applies its pass/deny action. Table
// inserts and deletes arrive on the same channel as packets.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                        Handshake
//   request    start, busy, req_item        item taken when start && !busy
//   response   rsp_valid, rsp_item          one-cycle strobe, cannot be held off
//
// Every item gives exactly one result item, in order. A non-IPv4 or
// loopback packet and an unused request type are answered from the idle
// state. Every other item scans the four keyed tables one entry per cycle
// through their key memory read ports, then steps through the flush, mask,
// AND, action and done states.
// After reset the engine clears every entry of the key and protocol
// memories, one entry per cycle; busy stays high meanwhile. A two-item
// queue between the decoder and the engine lets a new item be taken while
// the engine is still working; busy rises when it fills.
// ----------------------------------------------------------------------------
module bitvector_packet_classifier
   import bvpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   cmd_type front_cmd;
   cmd_type q_head;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   logic    clearing;
   logic    accept;

   // Items are refused while the memories are being cleared or the queue is full.
   assign busy   = q_full || clearing;
   assign accept = start && !busy;

   bvpc_front u_front (
      .req_item (req_item),
      .cmd      (front_cmd)
   );

   bvpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   bvpc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire

[hw/rtl/bvpc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvpc_front: request decoder
// Sorts each item into lookup, table write, bypass or no-op and prepares
// the search keys for the engine.
// ----------------------------------------------------------------------------
module bvpc_front
   import bvpc_pkg::*;
(
   input  req_item_type req_item,
   output cmd_type      cmd
);

   logic bypass;
   logic ports;

   assign bypass = (req_item.ip_version != IP_VERSION_4) ||
                   (req_item.src_addr == LOOPBACK_ADDR) ||
                   (req_item.dst_addr == LOOPBACK_ADDR);
   assign ports  = (req_item.protocol == PROTO_TCP) || (req_item.protocol == PROTO_UDP);

   always_comb begin
      cmd        = '0;
      cmd.sel    = req_item.table_select;
      cmd.value  = req_item.entry_value;
      case (req_item.req_type)
         REQ_CLASSIFY: begin
            cmd.kind   = bypass ? CMD_PASS : CMD_LOOKUP;
            cmd.key_sa = req_item.src_addr;
            cmd.key_da = req_item.dst_addr;
            cmd.key_pr = req_item.protocol;
            cmd.key_sp = ports ? req_item.src_port : 16'd0;
            cmd.key_dp = ports ? req_item.dst_port : 16'd0;
            cmd.ttl    = req_item.ttl;
            cmd.egress = req_item.egress_dir;
            cmd.ports  = ports;
         end
         REQ_INSERT, REQ_DELETE: begin
            cmd.kind   = (req_item.req_type == REQ_INSERT) ? CMD_INSERT : CMD_DELETE;
            cmd.key_sa = req_item.entry_key;
            cmd.key_da = req_item.entry_key;
            cmd.key_pr = req_item.entry_key[7:0];
            cmd.key_sp = req_item.entry_key[15:0];
            cmd.key_dp = req_item.entry_key[15:0];
         end
         default: begin
            cmd.kind = CMD_NOP;
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/bvpc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvpc_queue: command queue
// Small first-in first-out buffer between the decoder and the engine.
// ----------------------------------------------------------------------------
module bvpc_queue
   import bvpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full      = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/bvpc_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bvpc_engine: table engine
// Holds the rule tables, scans the keyed tables, carries out lookups and
// table writes, and drives the result register.
// ----------------------------------------------------------------------------
module bvpc_engine
   import bvpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_not_empty,
   input  cmd_type      q_head,
   output logic         q_pop,
   output logic         clearing,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_SCAN  = 8'b00000100,
      S_FLUSH = 8'b00001000,
      S_MASK  = 8'b00010000,
      S_AND   = 8'b00100000,
      S_ACT   = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   localparam int NT = 4;   // keyed tables: src addr, dst addr, src port, dst port

   state_type         state_ff, state_in;
   logic [CLR_AW-1:0] idx_ff, idx_in;
   logic [CLR_AW-1:0] rd_idx_ff;
   logic              rd_vld_ff, rd_vld_in;
   cmd_type           cmd_ff, cmd_in;
   logic              hit_ff [NT], hit_in [NT];
   logic              zero_ff [NT], zero_in [NT];
   logic              free_ff [NT], free_in [NT];
   logic [SCAN_AW-1:0] hit_idx_ff [NT], hit_idx_in [NT];
   logic [SCAN_AW-1:0] free_idx_ff [NT], free_idx_in [NT];
   logic [31:0]       bm_ff, bm_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              act_valid_ff [ACT_ENTRIES];
   logic              act_pass_ff [ACT_ENTRIES];
   logic              act_vld_q, act_pass_q;

   logic [32:0] sa_key_mem [IP_ENTRIES];
   logic [31:0] sa_mask_mem [IP_ENTRIES];
   logic [32:0] da_key_mem [IP_ENTRIES];
   logic [31:0] da_mask_mem [IP_ENTRIES];
   logic [16:0] sp_key_mem [PORT_ENTRIES];
   logic [31:0] sp_mask_mem [PORT_ENTRIES];
   logic [16:0] dp_key_mem [PORT_ENTRIES];
   logic [31:0] dp_mask_mem [PORT_ENTRIES];
   logic [32:0] proto_mem [PROTO_ENTRIES];

   logic [32:0] sa_key_q, da_key_q;
   logic [16:0] sp_key_q, dp_key_q;
   logic [31:0] sa_mask_q, da_mask_q, sp_mask_q, dp_mask_q;
   logic [32:0] pr_q, pr0_q;

   logic        kv [NT];
   logic [31:0] kk [NT];
   logic [31:0] skey [NT];
   logic        in_range [NT];
   logic [31:0] mask_q [NT];
   logic [31:0] tbm [NT];
   logic [31:0] pr_bm;

   logic        key_we [NT];
   logic [SCAN_AW-1:0] key_wa [NT];
   logic        key_wvalid [NT];
   logic        mask_we [NT];
   logic        proto_we;
   logic [PROTO_AW-1:0] proto_wa;
   logic [32:0] proto_wd;
   logic        act_we;
   logic        act_wvalid;
   logic [ACT_AW-1:0] act_idx;
   logic        act_bad;

   logic        scan_last, clear_last, ip_clr_ok, port_clr_ok, pr_clr_ok;
   logic [31:0] rule_id;
   logic        ones;
   logic [SCAN_AW-1:0] w_idx;
   logic        tsel_valid;
   int          tsel;

   assign scan_last   = idx_ff == CLR_AW'(SCAN_DEPTH - 1);
   assign clear_last  = idx_ff == CLR_AW'(CLR_DEPTH - 1);
   assign ip_clr_ok   = {1'b0, idx_ff} < (CLR_AW+1)'(IP_ENTRIES);
   assign port_clr_ok = {1'b0, idx_ff} < (CLR_AW+1)'(PORT_ENTRIES);
   assign pr_clr_ok   = {1'b0, idx_ff} < (CLR_AW+1)'(PROTO_ENTRIES);

   // Returned key words, aligned with the index that was read.
   always_comb begin
      kv[0] = sa_key_q[32];  kk[0] = sa_key_q[31:0];
      kv[1] = da_key_q[32];  kk[1] = da_key_q[31:0];
      kv[2] = sp_key_q[16];  kk[2] = {16'd0, sp_key_q[15:0]};
      kv[3] = dp_key_q[16];  kk[3] = {16'd0, dp_key_q[15:0]};
      skey[0] = cmd_ff.key_sa;
      skey[1] = cmd_ff.key_da;
      skey[2] = {16'd0, cmd_ff.key_sp};
      skey[3] = {16'd0, cmd_ff.key_dp};
      in_range[0] = {1'b0, rd_idx_ff} < (CLR_AW+1)'(IP_ENTRIES);
      in_range[1] = in_range[0];
      in_range[2] = {1'b0, rd_idx_ff} < (CLR_AW+1)'(PORT_ENTRIES);
      in_range[3] = in_range[2];
      mask_q[0] = sa_mask_q;
      mask_q[1] = da_mask_q;
      mask_q[2] = sp_mask_q;
      mask_q[3] = dp_mask_q;
   end

   // Bitmap of each table: the stored one on a hit, else empty when key 0 is
   // present, else all-ones.
   always_comb begin
      for (int t = 0; t < NT; t++) begin
         tbm[t] = hit_ff[t] ? mask_q[t] : (zero_ff[t] ? 32'd0 : ALL_ONES);
      end
      pr_bm = pr_q[32] ? pr_q[31:0] : (pr0_q[32] ? 32'd0 : ALL_ONES);
   end

   // Table selected by a write, as an index into the keyed-table arrays.
   always_comb begin
      tsel_valid = 1'b1;
      tsel       = 0;
      case (cmd_ff.sel)
         SEL_SRC_ADDR: tsel = 0;
         SEL_DST_ADDR: tsel = 1;
         SEL_SRC_PORT: tsel = 2;
         SEL_DST_PORT: tsel = 3;
         default:      tsel_valid = 1'b0;
      endcase
   end

   assign ones    = bm_ff == ALL_ONES;
   assign rule_id = ones ? 32'd0 : (bm_ff & (~bm_ff + 32'd1));
   assign w_idx   = hit_ff[tsel] ? hit_idx_ff[tsel] : free_idx_ff[tsel];
   assign {act_bad, act_idx} = (cmd_ff.kind == CMD_LOOKUP) ? act_slot(rule_id)
                                                           : act_slot(cmd_ff.key_sa);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      cmd_in       = cmd_ff;
      bm_in        = bm_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      q_pop        = 1'b0;
      proto_we     = 1'b0;
      proto_wa     = cmd_ff.key_pr;
      proto_wd     = {1'b1, cmd_ff.value};
      act_we       = 1'b0;
      act_wvalid   = 1'b0;
      for (int t = 0; t < NT; t++) begin
         hit_in[t]      = hit_ff[t];
         zero_in[t]     = zero_ff[t];
         free_in[t]     = free_ff[t];
         hit_idx_in[t]  = hit_idx_ff[t];
         free_idx_in[t] = free_idx_ff[t];
         key_we[t]      = 1'b0;
         key_wa[t]      = w_idx;
         key_wvalid[t]  = 1'b0;
         mask_we[t]     = 1'b0;
      end

      // Compare one returned entry of every keyed table per cycle.
      if (rd_vld_ff) begin
         for (int t = 0; t < NT; t++) begin
            if (in_range[t] && kv[t] && kk[t] == skey[t]) begin
               hit_in[t]     = 1'b1;
               hit_idx_in[t] = rd_idx_ff[SCAN_AW-1:0];
            end
            if (in_range[t] && kv[t] && kk[t] == 32'd0) begin
               zero_in[t] = 1'b1;
            end
            if (in_range[t] && !kv[t] && !free_ff[t]) begin
               free_in[t]     = 1'b1;
               free_idx_in[t] = rd_idx_ff[SCAN_AW-1:0];
            end
         end
      end

      case (state_ff)
         S_CLEAR: begin
            for (int t = 0; t < NT; t++) begin
               key_wa[t] = idx_ff[SCAN_AW-1:0];
            end
            key_we[0] = ip_clr_ok;
            key_we[1] = ip_clr_ok;
            key_we[2] = port_clr_ok;
            key_we[3] = port_clr_ok;
            proto_we  = pr_clr_ok;
            proto_wa  = idx_ff[PROTO_AW-1:0];
            proto_wd  = '0;
            idx_in    = idx_ff + 1'b1;
            if (clear_last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  CMD_PASS: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.allowed = 1'b1;
                  end
                  CMD_LOOKUP, CMD_INSERT, CMD_DELETE: begin
                     cmd_in   = q_head;
                     idx_in   = '0;
                     state_in = S_SCAN;
                     for (int t = 0; t < NT; t++) begin
                        hit_in[t]  = 1'b0;
                        zero_in[t] = 1'b0;
                        free_in[t] = 1'b0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (scan_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_MASK;
         end
         S_MASK: begin
            state_in = S_AND;
         end
         S_AND: begin
            bm_in = tbm[0] & tbm[1] & pr_bm;
            if (cmd_ff.ports) begin
               bm_in = bm_in & tbm[2] & tbm[3];
            end
            state_in = S_ACT;
         end
         S_ACT: begin
            // The action entry of the rule or write key is read this cycle.
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (cmd_ff.kind == CMD_LOOKUP) begin
               rsp_in.allowed = 1'b1;
               if (!ones && act_vld_q) begin
                  rsp_in.allowed = act_pass_q;
               end
               rsp_in.record_valid = 1'b1;
               rsp_in.rec_flags    = {~rsp_in.allowed, cmd_ff.egress};
               rsp_in.rule_id      = rule_id;
               rsp_in.rec_ttl      = cmd_ff.ttl;
               rsp_in.rec_protocol = cmd_ff.key_pr;
               rsp_in.rec_src_addr = cmd_ff.key_sa;
               rsp_in.rec_dst_addr = cmd_ff.key_da;
               rsp_in.rec_src_port = cmd_ff.key_sp;
               rsp_in.rec_dst_port = cmd_ff.key_dp;
            end else if (cmd_ff.sel == SEL_PROTO) begin
               if (cmd_ff.kind == CMD_INSERT) begin
                  proto_we = 1'b1;
               end else if (pr_q[32]) begin
                  proto_we = 1'b1;
                  proto_wd = '0;
               end else begin
                  rsp_in.write_status = ST_ABSENT;
               end
            end else if (cmd_ff.sel == SEL_ACTION) begin
               if (act_bad) begin
                  rsp_in.write_status = ST_BAD_KEY;
               end else if (cmd_ff.kind == CMD_INSERT) begin
                  act_we     = 1'b1;
                  act_wvalid = 1'b1;
               end else if (act_vld_q) begin
                  act_we = 1'b1;
               end else begin
                  rsp_in.write_status = ST_ABSENT;
               end
            end else if (tsel_valid) begin
               if (cmd_ff.kind == CMD_INSERT) begin
                  if (hit_ff[tsel] || free_ff[tsel]) begin
                     key_we[tsel]     = 1'b1;
                     key_wvalid[tsel] = 1'b1;
                     mask_we[tsel]    = 1'b1;
                  end else begin
                     rsp_in.write_status = ST_FULL;
                  end
               end else if (hit_ff[tsel]) begin
                  key_we[tsel] = 1'b1;
               end else begin
                  rsp_in.write_status = ST_ABSENT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < ACT_ENTRIES; a++) begin
            act_valid_ff[a] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (act_we) begin
            act_valid_ff[act_idx] <= act_wvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= idx_ff;
      cmd_ff     <= cmd_in;
      bm_ff      <= bm_in;
      rsp_ff     <= rsp_in;
      act_vld_q  <= act_valid_ff[act_idx];
      act_pass_q <= act_pass_ff[act_idx];
      for (int t = 0; t < NT; t++) begin
         hit_ff[t]      <= hit_in[t];
         zero_ff[t]     <= zero_in[t];
         free_ff[t]     <= free_in[t];
         hit_idx_ff[t]  <= hit_idx_in[t];
         free_idx_ff[t] <= free_idx_in[t];
      end
      if (act_we) begin
         act_pass_ff[act_idx] <= cmd_ff.value[0];
      end
   end

   // Key stores: one write port, one registered read port swept by the scan.
   always_ff @(posedge clock) begin
      if (key_we[0]) begin
         sa_key_mem[key_wa[0][IP_AW-1:0]] <= {key_wvalid[0], cmd_ff.key_sa};
      end
      sa_key_q <= sa_key_mem[idx_ff[IP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (key_we[1]) begin
         da_key_mem[key_wa[1][IP_AW-1:0]] <= {key_wvalid[1], cmd_ff.key_da};
      end
      da_key_q <= da_key_mem[idx_ff[IP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (key_we[2]) begin
         sp_key_mem[key_wa[2][PORT_AW-1:0]] <= {key_wvalid[2], cmd_ff.key_sp};
      end
      sp_key_q <= sp_key_mem[idx_ff[PORT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (key_we[3]) begin
         dp_key_mem[key_wa[3][PORT_AW-1:0]] <= {key_wvalid[3], cmd_ff.key_dp};
      end
      dp_key_q <= dp_key_mem[idx_ff[PORT_AW-1:0]];
   end

   // Bitmap stores, read at the index where the scan found the key.
   always_ff @(posedge clock) begin
      if (mask_we[0]) begin
         sa_mask_mem[w_idx[IP_AW-1:0]] <= cmd_ff.value;
      end
      sa_mask_q <= sa_mask_mem[hit_idx_ff[0][IP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mask_we[1]) begin
         da_mask_mem[w_idx[IP_AW-1:0]] <= cmd_ff.value;
      end
      da_mask_q <= da_mask_mem[hit_idx_ff[1][IP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mask_we[2]) begin
         sp_mask_mem[w_idx[PORT_AW-1:0]] <= cmd_ff.value;
      end
      sp_mask_q <= sp_mask_mem[hit_idx_ff[2][PORT_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mask_we[3]) begin
         dp_mask_mem[w_idx[PORT_AW-1:0]] <= cmd_ff.value;
      end
      dp_mask_q <= dp_mask_mem[hit_idx_ff[3][PORT_AW-1:0]];
   end

   // Protocol table: direct-indexed, read at the item's protocol and at 0.
   always_ff @(posedge clock) begin
      if (proto_we) begin
         proto_mem[proto_wa] <= proto_wd;
      end
      pr_q  <= proto_mem[cmd_ff.key_pr];
      pr0_q <= proto_mem[PROTO_AW'(0)];
   end

   assign clearing  = state_ff == S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_no_rsp_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_FLUSH || state_ff == S_MASK) |-> !rsp_valid_ff)
      else $error("result strobe while a table scan is running");

   a_scan_cmd_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cmd_ff.kind == CMD_LOOKUP || cmd_ff.kind == CMD_INSERT ||
                                cmd_ff.kind == CMD_DELETE))
      else $error("scan started for an item that needs no table access");

   a_rule_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_ff.rule_id))
      else $error("rule id is not one-hot");

   a_deny_records: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.record_valid) |-> (rsp_ff.rec_flags[1] == !rsp_ff.allowed))
      else $error("flow record deny flag does not match the decision");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE))
      else $error("queue popped while the engine is busy");

endmodule
`default_nettype wire

[sim/bitvector_packet_classifier_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitvector_packet_classifier_tb: self-checking bench for the packet classifier
// Drives table writes and packet headers through the command channel and
// compares every result item against a behavioral model of the rule tables.
// Most random traffic reuses a small pool of keys, so lookups hit the tables.
// ----------------------------------------------------------------------------
module bitvector_packet_classifier_tb;
   import bvpc_pkg::*;

   // The scoreboard keeps its own copy of every rule table. For each accepted
   // item it computes the expected result item and queues it. Each strobed
   // result is checked against the oldest queued item.
   class classifier_scoreboard;
      logic [32:0] sa_keys [IP_ENTRIES];
      logic [31:0] sa_maps [IP_ENTRIES];
      logic [32:0] da_keys [IP_ENTRIES];
      logic [31:0] da_maps [IP_ENTRIES];
      logic [32:0] proto_tab [PROTO_ENTRIES];
      logic [16:0] sp_keys [PORT_ENTRIES];
      logic [31:0] sp_maps [PORT_ENTRIES];
      logic [16:0] dp_keys [PORT_ENTRIES];
      logic [31:0] dp_maps [PORT_ENTRIES];
      logic [1:0]  act_tab [ACT_ENTRIES];
      rsp_item_type pending [$];
      int mismatches;
      int classified;
      int records;
      int writes;

      function new();
         foreach (sa_keys[i]) begin
            sa_keys[i] = '0; sa_maps[i] = '0; da_keys[i] = '0; da_maps[i] = '0;
         end
         foreach (sp_keys[i]) begin
            sp_keys[i] = '0; sp_maps[i] = '0; dp_keys[i] = '0; dp_maps[i] = '0;
         end
         foreach (proto_tab[i]) proto_tab[i] = '0;
         foreach (act_tab[i]) act_tab[i] = '0;
         mismatches = 0; classified = 0; records = 0; writes = 0;
      endfunction

      // Slot of an action key, or -1 when the key is neither zero nor one-hot.
      function int action_index(logic [31:0] key);
         if (key == 0) return 0;
         if ((key & (key - 1)) != 0) return -1;
         for (int b = 0; b < 32; b++) if (key[b]) return b + 1;
         return -1;
      endfunction

      function int find_ip(ref logic [32:0] keys [IP_ENTRIES], input logic [31:0] key);
         foreach (keys[i]) if (keys[i] == {1'b1, key}) return i;
         return -1;
      endfunction

      function int find_port(ref logic [16:0] keys [PORT_ENTRIES], input logic [15:0] key);
         foreach (keys[i]) if (keys[i] == {1'b1, key}) return i;
         return -1;
      endfunction

      function logic [31:0] ip_bitmap(ref logic [32:0] keys [IP_ENTRIES],
                                      ref logic [31:0] maps [IP_ENTRIES],
                                      input logic [31:0] key);
         int i;
         i = find_ip(keys, key);
         if (i >= 0) return maps[i];
         return (find_ip(keys, 32'd0) >= 0) ? 32'd0 : ALL_ONES;
      endfunction

      function logic [31:0] port_bitmap(ref logic [16:0] keys [PORT_ENTRIES],
                                        ref logic [31:0] maps [PORT_ENTRIES],
                                        input logic [15:0] key);
         int i;
         i = find_port(keys, key);
         if (i >= 0) return maps[i];
         return (find_port(keys, 16'd0) >= 0) ? 32'd0 : ALL_ONES;
      endfunction

      function status_type write_ip(ref logic [32:0] keys [IP_ENTRIES],
                                    ref logic [31:0] maps [IP_ENTRIES],
                                    input bit ins, input logic [31:0] key,
                                    input logic [31:0] val);
         int i;
         i = find_ip(keys, key);
         if (!ins) begin
            if (i < 0) return ST_ABSENT;
            keys[i] = '0;
            return ST_OK;
         end
         if (i < 0) begin
            foreach (keys[j]) if (!keys[j][32]) begin i = j; break; end
            if (i < 0) return ST_FULL;
         end
         keys[i] = {1'b1, key};
         maps[i] = val;
         return ST_OK;
      endfunction

      function status_type write_port(ref logic [16:0] keys [PORT_ENTRIES],
                                      ref logic [31:0] maps [PORT_ENTRIES],
                                      input bit ins, input logic [15:0] key,
                                      input logic [31:0] val);
         int i;
         i = find_port(keys, key);
         if (!ins) begin
            if (i < 0) return ST_ABSENT;
            keys[i] = '0;
            return ST_OK;
         end
         if (i < 0) begin
            foreach (keys[j]) if (!keys[j][16]) begin i = j; break; end
            if (i < 0) return ST_FULL;
         end
         keys[i] = {1'b1, key};
         maps[i] = val;
         return ST_OK;
      endfunction

      function status_type table_write(req_item_type r);
         bit ins;
         int s;
         ins = (r.req_type == REQ_INSERT);
         case (r.table_select)
            SEL_SRC_ADDR: return write_ip(sa_keys, sa_maps, ins, r.entry_key, r.entry_value);
            SEL_DST_ADDR: return write_ip(da_keys, da_maps, ins, r.entry_key, r.entry_value);
            SEL_PROTO: begin
               if (ins) begin
                  proto_tab[r.entry_key[7:0]] = {1'b1, r.entry_value};
                  return ST_OK;
               end
               if (!proto_tab[r.entry_key[7:0]][32]) return ST_ABSENT;
               proto_tab[r.entry_key[7:0]] = '0;
               return ST_OK;
            end
            SEL_SRC_PORT: return write_port(sp_keys, sp_maps, ins, r.entry_key[15:0],
                                            r.entry_value);
            SEL_DST_PORT: return write_port(dp_keys, dp_maps, ins, r.entry_key[15:0],
                                            r.entry_value);
            SEL_ACTION: begin
               s = action_index(r.entry_key);
               if (s < 0) return ST_BAD_KEY;
               if (ins) begin
                  act_tab[s] = {1'b1, r.entry_value[0]};
                  return ST_OK;
               end
               if (!act_tab[s][1]) return ST_ABSENT;
               act_tab[s] = '0;
               return ST_OK;
            end
            default: return ST_OK;
         endcase
      endfunction

      // Notes one accepted item and queues the result it must produce.
      function void note_request(req_item_type r);
         rsp_item_type e;
         logic [31:0] bm;
         logic [15:0] sp, dp;
         bit ports;
         int s;
         e = '0;
         if (r.req_type == REQ_INSERT || r.req_type == REQ_DELETE) begin
            e.write_status = table_write(r);
            writes++;
         end else if (r.req_type == REQ_CLASSIFY) begin
            classified++;
            e.allowed = 1'b1;
            if (r.ip_version == IP_VERSION_4 && r.src_addr != LOOPBACK_ADDR &&
                r.dst_addr != LOOPBACK_ADDR) begin
               ports = (r.protocol == PROTO_TCP || r.protocol == PROTO_UDP);
               sp = ports ? r.src_port : 16'd0;
               dp = ports ? r.dst_port : 16'd0;
               bm = ip_bitmap(sa_keys, sa_maps, r.src_addr);
               bm &= ip_bitmap(da_keys, da_maps, r.dst_addr);
               if (proto_tab[r.protocol][32]) bm &= proto_tab[r.protocol][31:0];
               else if (proto_tab[0][32]) bm = '0;
               if (ports) begin
                  bm &= port_bitmap(sp_keys, sp_maps, sp);
                  bm &= port_bitmap(dp_keys, dp_maps, dp);
               end
               if (bm != ALL_ONES) begin
                  e.rule_id = bm & (~bm + 32'd1);
                  s = action_index(e.rule_id);
                  if (s >= 0 && act_tab[s][1]) e.allowed = act_tab[s][0];
               end
               e.record_valid = 1'b1;
               e.rec_flags = {~e.allowed, r.egress_dir};
               e.rec_ttl = r.ttl;
               e.rec_protocol = r.protocol;
               e.rec_src_addr = r.src_addr;
               e.rec_dst_addr = r.dst_addr;
               e.rec_src_port = sp;
               e.rec_dst_port = dp;
               records++;
            end
         end
         pending.push_back(e);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", field, want, got);
      endfunction

      // Compares one strobed result with the oldest queued item.
      function void check_result(rsp_item_type got);
         rsp_item_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.allowed !== e.allowed) report("allowed", e.allowed, got.allowed);
         if (got.record_valid !== e.record_valid)
            report("record_valid", e.record_valid, got.record_valid);
         if (got.rec_flags !== e.rec_flags) report("rec_flags", e.rec_flags, got.rec_flags);
         if (got.rule_id !== e.rule_id) report("rule_id", e.rule_id, got.rule_id);
         if (got.rec_ttl !== e.rec_ttl) report("rec_ttl", e.rec_ttl, got.rec_ttl);
         if (got.rec_protocol !== e.rec_protocol)
            report("rec_protocol", e.rec_protocol, got.rec_protocol);
         if (got.rec_src_addr !== e.rec_src_addr)
            report("rec_src_addr", e.rec_src_addr, got.rec_src_addr);
         if (got.rec_dst_addr !== e.rec_dst_addr)
            report("rec_dst_addr", e.rec_dst_addr, got.rec_dst_addr);
         if (got.rec_src_port !== e.rec_src_port)
            report("rec_src_port", e.rec_src_port, got.rec_src_port);
         if (got.rec_dst_port !== e.rec_dst_port)
            report("rec_dst_port", e.rec_dst_port, got.rec_dst_port);
         if (got.write_status !== e.write_status)
            report("write_status", e.write_status, got.write_status);
      endfunction
   endclass

   // A scanned item sweeps every entry of the larger keyed table, so the idle
   // limit must cover the post-reset clear plus a queue of such items with margin.
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1280;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   classifier_scoreboard board;
   int  idle_cycles;
   int  sent;

   // Small key pools so that random packets find entries that were written.
   logic [31:0] addr_pool [8];
   logic [15:0] port_pool [6];
   logic [7:0]  proto_pool [5];

   bitvector_packet_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Results and accepted items are sampled at the rising edge, before the
   // bench updates its drives with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp_item);
         if (start && !busy) begin
            board.note_request(req_item);
            sent++;
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("[bitvector_packet_classifier] ERROR");
            $finish;
         end
      end
   end

   // Random gap: mostly none or short, now and then long. With no gap the
   // next item follows at once and start simply stays high.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 50) n = 0;
      else if (n < 92) n = $urandom_range(1, 4);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Presents one item and holds it until the block takes it.
   task automatic send_item(req_item_type r);
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      idle_gap();
   endtask

   // Random filler for the fields that an item does not use.
   function automatic req_item_type rand_item();
      logic [191:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return noise[$bits(req_item_type)-1:0];
   endfunction

   task automatic send_write(req_kind_type kind, sel_type sel, logic [31:0] key,
                             logic [31:0] val);
      req_item_type r;
      r = rand_item();
      r.req_type = kind;
      r.table_select = sel;
      r.entry_key = key;
      r.entry_value = val;
      send_item(r);
   endtask

   task automatic send_packet(logic [3:0] ver, logic [31:0] sa, logic [31:0] da,
                              logic [7:0] pr, logic [15:0] sp, logic [15:0] dp);
      req_item_type r;
      r = rand_item();
      r.req_type = REQ_CLASSIFY;
      r.ip_version = ver;
      r.src_addr = sa;
      r.dst_addr = da;
      r.protocol = pr;
      r.src_port = sp;
      r.dst_port = dp;
      send_item(r);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key(sel_type sel);
      case (sel)
         SEL_SRC_ADDR, SEL_DST_ADDR: return addr_pool[$urandom_range(0, 7)];
         SEL_PROTO: return {$urandom_range(0, 1) ? 24'd0 : 24'($urandom),
                            proto_pool[$urandom_range(0, 4)]};
         SEL_SRC_PORT, SEL_DST_PORT:
            return {16'($urandom), port_pool[$urandom_range(0, 5)]};
         default: begin
            if ($urandom_range(0, 9) == 0) return $urandom;
            if ($urandom_range(0, 5) == 0) return 32'd0;
            return 32'd1 << $urandom_range(0, 31);
         end
      endcase
   endfunction

   // Mixed bitmaps, all-ones, empty or random, make the lowest set bit and empty results both common.
   function automatic logic [31:0] pick_bitmap();
      case ($urandom_range(0, 4))
         0: return ALL_ONES;
         1: return 32'd0;
         2: return $urandom | $urandom;
         default: return ~(32'd1 << $urandom_range(0, 31)) & $urandom;
      endcase
   endfunction

   task automatic random_item();
      int pick;
      sel_type sel;
      req_item_type r;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         sel = sel_type'($urandom_range(0, 5));
         send_write((pick < 25) ? REQ_INSERT : REQ_DELETE, sel, pick_key(sel),
                    pick_bitmap());
      end else if (pick < 92) begin
         send_packet(($urandom_range(0, 19) == 0) ? 4'($urandom) : IP_VERSION_4,
                     ($urandom_range(0, 6) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)],
                     ($urandom_range(0, 6) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)],
                     ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                 : proto_pool[$urandom_range(0, 4)],
                     ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                 : port_pool[$urandom_range(0, 5)],
                     ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                 : port_pool[$urandom_range(0, 5)]);
      end else begin
         // Fully random noise, including unused request types and selects.
         r = rand_item();
         if (r.req_type != REQ_NONE && r.table_select <= SEL_ACTION &&
             $urandom_range(0, 1)) r.table_select = 3'($urandom_range(6, 7));
         send_item(r);
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      idle_cycles = 0;
      sent = 0;
      addr_pool = '{32'd0, ALL_ONES, 32'h0A00_0001, 32'hC0A8_0101, 32'h0808_0808,
                    32'h7F00_0002, 32'hAC10_0005, 32'h0000_0001};
      port_pool = '{16'd0, 16'hFFFF, 16'd80, 16'd443, 16'd53, 16'd22};
      proto_pool = '{8'd0, PROTO_TCP, PROTO_UDP, 8'd1, 8'hFF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty tables, then a small rule set and each special case.
      send_packet(IP_VERSION_4, 32'h0A00_0001, 32'hC0A8_0101, PROTO_TCP, 16'd1, 16'd80);
      send_packet(4'd6, 32'h0A00_0001, 32'hC0A8_0101, PROTO_TCP, 16'd1, 16'd80);
      send_packet(IP_VERSION_4, LOOPBACK_ADDR, 32'h0808_0808, PROTO_UDP, 16'd5, 16'd53);
      send_packet(IP_VERSION_4, 32'h0808_0808, LOOPBACK_ADDR, PROTO_UDP, 16'd5, 16'd53);
      send_write(REQ_INSERT, SEL_SRC_ADDR, 32'h0A00_0001, 32'h0000_00F0);
      send_write(REQ_INSERT, SEL_DST_ADDR, ALL_ONES, 32'h8000_0030);
      send_write(REQ_INSERT, SEL_PROTO, 32'hABCD_FF06, 32'h0000_0FF0);
      send_write(REQ_INSERT, SEL_SRC_PORT, 32'h1234_FFFF, ALL_ONES);
      send_write(REQ_INSERT, SEL_DST_PORT, 32'h0000_0050, 32'h0000_0020);
      send_write(REQ_INSERT, SEL_ACTION, 32'h0000_0020, 32'd0);
      send_write(REQ_INSERT, SEL_ACTION, 32'h0000_0006, 32'd1);
      send_write(REQ_DELETE, SEL_SRC_PORT, 32'd7, 32'd0);
      send_write(REQ_DELETE, SEL_ACTION, 32'h8000_0000, 32'd0);
      send_packet(IP_VERSION_4, 32'h0A00_0001, ALL_ONES, PROTO_TCP, 16'hFFFF, 16'd80);
      send_packet(IP_VERSION_4, 32'h0A00_0001, ALL_ONES, 8'd1, 16'hFFFF, 16'd80);
      send_write(REQ_INSERT, SEL_SRC_ADDR, 32'd0, 32'd0);
      send_write(REQ_INSERT, SEL_PROTO, 32'd0, ALL_ONES);
      send_write(REQ_INSERT, SEL_ACTION, 32'd0, 32'd0);
      send_packet(IP_VERSION_4, 32'h0102_0304, ALL_ONES, PROTO_UDP, 16'd0, 16'hFFFF);
      send_write(REQ_DELETE, SEL_PROTO, 32'd0, 32'd0);
      send_write(REQ_DELETE, SEL_PROTO, 32'd0, 32'd0);
      send_write(REQ_INSERT, sel_type'(3'd6), 32'd1, 32'd1);
      send_write(REQ_NONE, sel_type'(3'd7), 32'd1, 32'd1);
      send_write(REQ_DELETE, SEL_SRC_ADDR, 32'd0, 32'd0);

      // The sender holds off until every result is back.
      wait_drained();
      repeat (RANDOM_ITEMS) random_item();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("covered %0d items: %0d table writes, %0d classify requests, %0d records",
               sent, board.writes, board.classified, board.records);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[bitvector_packet_classifier] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("[bitvector_packet_classifier] ERROR");
      end
      $finish;
   end

endmodule
